// ===== sv/ckvt_pkg.sv =====
// shared types and constants for the counting key/value table
package ckvt_pkg;

  localparam int KEY_IN_W = 32;
  localparam int VALUE_W  = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_MATCH,
    ST_UPDATE
  } ckvt_state_t;

  typedef struct packed {
    logic clr_step;
    logic load_key;
    logic mod_step;
    logic rd_en;
    logic cmp_en;
    logic commit;
  } ckvt_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic out_free;
  } ckvt_status_t;

endpackage

// ===== sv/counting_key_value_table.sv =====
// top level of the counting key/value table
//
//   channel | ports                                           | direction
//   input   | in_valid in_ready in_key in_increment           | request in
//   result  | out_valid out_ready out_value out_inserted      | result out
//           | out_bucket_full                                 |
//
// a request goes through four steps to reduce the key to its bucket
// (multiply, subtract, correct, done), then bucket read, way match and commit,
// before the next request can be taken
// after reset a clearing pass over the valid marks of every bucket runs first,
// during which in_ready stays low
// a stalled result waits in the output register while the next request is
// taken; that request then holds in its commit step until the result leaves
module counting_key_value_table #(
  parameter int BUCKETS  = 4096,
  parameter int WAYS     = 4,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ckvt_pkg::KEY_IN_W-1:0] in_key,
  input  logic                          in_increment,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ckvt_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_inserted,
  output logic                          out_bucket_full
);
  import ckvt_pkg::*;

  ckvt_cmd_t    cmd;
  ckvt_status_t status;

  ckvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ckvt_dpath #(
    .BUCKETS  (BUCKETS),
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_key          (in_key),
    .in_increment    (in_increment),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_inserted    (out_inserted),
    .out_bucket_full (out_bucket_full)
  );

  // a commit never overwrites a result that has not been transferred
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result register occupied");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inserted && out_bucket_full))
    else $error("inserted and bucket_full both set");

  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inserted) |-> (out_value == VALUE_W'(1)))
    else $error("inserted entry does not report one");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bucket_full) |-> (out_value == '0))
    else $error("full bucket does not report zero");

endmodule

// ===== sv/ckvt_ctrl.sv =====
// controller state machine: clearing pass, bucket reduction, read, match, commit
module ckvt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ckvt_pkg::ckvt_status_t status,
  output ckvt_pkg::ckvt_cmd_t    cmd
);
  import ckvt_pkg::*;

  ckvt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_nxt    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status.mod_done) begin
          state_nxt = ST_READ;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold until the result register can take the transfer
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/ckvt_dpath.sv =====
// datapath: bucket reduction, bucket row memory, way compare, update and result register
module ckvt_dpath #(
  parameter int BUCKETS  = 4096,
  parameter int WAYS     = 4,
  parameter int KEY_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ckvt_pkg::ckvt_cmd_t           cmd,
  output ckvt_pkg::ckvt_status_t        status,
  input  logic [ckvt_pkg::KEY_IN_W-1:0] in_key,
  input  logic                          in_increment,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ckvt_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_inserted,
  output logic                          out_bucket_full
);
  import ckvt_pkg::*;

  localparam int SKW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int BW  = $clog2(BUCKETS);
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam longint unsigned RECIP_FULL = (64'd1 << KEY_IN_W) / 64'(BUCKETS);
  localparam logic [KEY_IN_W-1:0] RECIP     = KEY_IN_W'(RECIP_FULL);
  localparam logic [KEY_IN_W-1:0] BUCKETS_W = KEY_IN_W'(BUCKETS);
  localparam logic [BW-1:0] LAST_ADDR = BW'(BUCKETS - 1);
  localparam logic [1:0]    STEP_MUL  = 2'd0;
  localparam logic [1:0]    STEP_SUB  = 2'd1;
  localparam logic [1:0]    STEP_FIX  = 2'd2;
  localparam logic [1:0]    MOD_STEPS = 2'd3;

  // bucket rows
  logic [WAYS-1:0]                 valid_mem [BUCKETS];
  logic [WAYS-1:0][SKW-1:0]        key_mem   [BUCKETS];
  logic [WAYS-1:0][VALUE_W-1:0]    val_mem   [BUCKETS];

  logic [SKW-1:0]               key_r;
  logic                         inc_r;
  logic [2*KEY_IN_W-1:0]        prod_r;
  logic [KEY_IN_W-1:0]          est_r;
  logic [BW-1:0]                rem_r;
  logic [1:0]                   cnt_r;
  logic [BW-1:0]                clr_addr_r;
  logic [WAYS-1:0]              rd_valid_r;
  logic [WAYS-1:0][SKW-1:0]     rd_key_r;
  logic [WAYS-1:0][VALUE_W-1:0] rd_val_r;
  logic                         hit_r, free_r;
  logic [WW-1:0]                hit_idx_r, free_idx_r;
  logic [VALUE_W-1:0]           hit_val_r;
  logic                         out_valid_r;
  logic [VALUE_W-1:0]           out_value_r;
  logic                         out_inserted_r, out_full_r;

  logic [KEY_IN_W-1:0]          key_ext;
  logic [KEY_IN_W-1:0]          quot;
  logic [WAYS-1:0]              hit_vec;
  logic                         hit_any, free_any;
  logic [WW-1:0]                hit_idx, free_idx;
  logic [WAYS-1:0]              vld_row_nxt;
  logic [WAYS-1:0][SKW-1:0]     key_row_nxt;
  logic [WAYS-1:0][VALUE_W-1:0] val_row_nxt;
  logic                         wr_new, wr_val;
  logic [VALUE_W-1:0]           res_value;
  logic                         res_ins, res_full;
  logic [BW-1:0]                vld_addr;

  // reciprocal multiply gives the quotient exact or one low, one compare-and-subtract fixes it
  assign key_ext = KEY_IN_W'(key_r);
  assign quot    = prod_r[2*KEY_IN_W-1:KEY_IN_W];

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= in_key[SKW-1:0];
      inc_r <= in_increment;
    end else if (cmd.mod_step) begin
      case (cnt_r)
        STEP_MUL: begin
          prod_r <= (2*KEY_IN_W)'(key_ext) * (2*KEY_IN_W)'(RECIP);
        end
        STEP_SUB: begin
          est_r <= key_ext - quot * BUCKETS_W;
        end
        STEP_FIX: begin
          rem_r <= BW'((est_r >= BUCKETS_W) ? (est_r - BUCKETS_W) : est_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.load_key) begin
        cnt_r <= '0;
      end else if (cmd.mod_step) begin
        cnt_r <= cnt_r + 2'd1;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + BW'(1);
      end
    end
  end

  // lowest matching way and lowest free way
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = rd_valid_r[w] && (rd_key_r[w] == key_r);
      if (hit_vec[w]) begin
        hit_any = 1'b1;
        hit_idx = WW'(w);
      end
      if (!rd_valid_r[w]) begin
        free_any = 1'b1;
        free_idx = WW'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      hit_r      <= hit_any;
      free_r     <= free_any;
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
      hit_val_r  <= rd_val_r[hit_idx];
    end
  end

  // row rewrite for the commit cycle
  always_comb begin
    vld_row_nxt = rd_valid_r;
    key_row_nxt = rd_key_r;
    val_row_nxt = rd_val_r;
    wr_new      = 1'b0;
    wr_val      = 1'b0;
    res_value   = '0;
    res_ins     = 1'b0;
    res_full    = 1'b0;
    if (hit_r) begin
      res_value = hit_val_r;
      if (inc_r && (hit_val_r != '1)) begin
        val_row_nxt[hit_idx_r] = hit_val_r + VALUE_W'(1);
        wr_val                 = 1'b1;
      end
    end else if (free_r) begin
      vld_row_nxt[free_idx_r] = 1'b1;
      key_row_nxt[free_idx_r] = key_r;
      val_row_nxt[free_idx_r] = VALUE_W'(1);
      wr_new                  = 1'b1;
      wr_val                  = 1'b1;
      res_value               = VALUE_W'(1);
      res_ins                 = 1'b1;
    end else begin
      res_full = 1'b1;
    end
  end

  assign vld_addr = cmd.clr_step ? clr_addr_r : rem_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step || (cmd.commit && wr_new)) begin
      valid_mem[vld_addr] <= cmd.clr_step ? '0 : vld_row_nxt;
    end
    if (cmd.commit && wr_new) begin
      key_mem[rem_r] <= key_row_nxt;
    end
    if (cmd.commit && wr_val) begin
      val_mem[rem_r] <= val_row_nxt;
    end
    if (cmd.rd_en) begin
      rd_valid_r <= valid_mem[rem_r];
      rd_key_r   <= key_mem[rem_r];
      rd_val_r   <= val_mem[rem_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value_r    <= res_value;
      out_inserted_r <= res_ins;
      out_full_r     <= res_full;
    end
  end

  assign status.clr_done = (clr_addr_r == LAST_ADDR);
  assign status.mod_done = (cnt_r == MOD_STEPS);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_inserted    = out_inserted_r;
  assign out_bucket_full = out_full_r;

endmodule
